FILE: rtl/pis_pkg.sv
// ----------------------------------------------------------------------------
// Palette image scaler package
// Shared widths, command codes and register indexes.
// ----------------------------------------------------------------------------
package pis_pkg;

  localparam int FrameBytes  = 65536;
  localparam int FrameAw     = $clog2(FrameBytes);
  localparam int PaletteSize = 32;
  localparam int PalAw       = $clog2(PaletteSize);

  typedef enum logic [1:0] {
    CMD_WR_FRAME = 2'd0,
    CMD_WR_PAL   = 2'd1,
    CMD_RENDER   = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_SCALE_MODE  = 3'd0,
    REG_ROW_STRIDE  = 3'd1,
    REG_BASE_OFFSET = 3'd2,
    REG_X_STEP      = 3'd3,
    REG_Y_STEP      = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic        scale_mode;
    logic [8:0]  row_stride;
    logic [7:0]  base_offset;
    logic [23:0] x_step;
    logic [23:0] y_step;
  } cfg_t;

endpackage

FILE: rtl/pis_if.sv
// ----------------------------------------------------------------------------
// Palette image scaler channels
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface pis_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] address;
  logic [15:0] value;
  logic [9:0]  out_x;
  logic [9:0]  out_y;
  modport source (output valid, cmd, address, value, out_x, out_y, input ready);
  modport sink   (input valid, cmd, address, value, out_x, out_y, output ready);
endinterface

interface pis_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel;
  modport source (output valid, pixel, input ready);
  modport sink   (input valid, pixel, output ready);
endinterface

interface pis_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/palette_image_scaler_core.sv
// ----------------------------------------------------------------------------
// Palette image scaler core
// Throughput one item per cycle while the output is not stalled.
// The frame store is four banked copies, each read at one address per cycle.
// A stalled output freezes the whole pipeline; the input is taken while the
// final stage is empty or draining. Reset (rst_n low, synchronous) resets the
// config and valid bits; frame store and palette are undefined until written.
// ----------------------------------------------------------------------------
module palette_image_scaler_core
  import pis_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  pis_in_if.sink    in_ch,
  pis_out_if.source out_ch,
  pis_cfg_if.sink   cfg_ch
);

  cfg_t cfg_r;
  logic adv;

  // stage valid bits: s1 mult, s2 addr, s3 fram read, s4 palette read,
  // s5 blend mid, s6 output
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  assign adv = !v6_r || out_ch.ready;
  assign in_ch.ready  = adv;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale_mode  <= 1'b0;
      cfg_r.row_stride  <= 9'd256;
      cfg_r.base_offset <= 8'd0;
      cfg_r.x_step      <= 24'd65536;
      cfg_r.y_step      <= 24'd65536;
    end else if (cfg_ch.valid) begin
      case (reg_idx_t'(cfg_ch.index))
        REG_SCALE_MODE:  cfg_r.scale_mode  <= cfg_ch.data[0];
        REG_ROW_STRIDE:  cfg_r.row_stride  <= cfg_ch.data[8:0];
        REG_BASE_OFFSET: cfg_r.base_offset <= cfg_ch.data[7:0];
        REG_X_STEP:      cfg_r.x_step      <= cfg_ch.data[23:0];
        REG_Y_STEP:      cfg_r.y_step      <= cfg_ch.data[23:0];
        default: ;
      endcase
    end
  end

  logic acc;
  assign acc = in_ch.valid && adv;

  logic [4:0]  fb0 [FrameBytes];
  logic [4:0]  fb1 [FrameBytes];
  logic [4:0]  fb2 [FrameBytes];
  logic [4:0]  fb3 [FrameBytes];
  logic [15:0] pal [PaletteSize];

  // writes travel down the pipeline and land at the stage that reads the store
  logic             wf1_r, wp1_r, wf2_r, wp2_r, wp3_r;
  logic [15:0]      wa1_r, wd1_r, wa2_r, wd2_r, wd3_r;
  logic [PalAw-1:0] wa3_r;

  // stage 1: products
  logic [33:0] px_r, py_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      wf1_r <= 1'b0;
      wp1_r <= 1'b0;
    end else if (adv) begin
      v1_r  <= acc && (cmd_t'(in_ch.cmd) == CMD_RENDER);
      wf1_r <= acc && (cmd_t'(in_ch.cmd) == CMD_WR_FRAME);
      wp1_r <= acc && (cmd_t'(in_ch.cmd) == CMD_WR_PAL);
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      px_r  <= {24'd0, in_ch.out_x} * {10'd0, cfg_r.x_step};
      py_r  <= {24'd0, in_ch.out_y} * {10'd0, cfg_r.y_step};
      wa1_r <= in_ch.address;
      wd1_r <= in_ch.value;
    end
  end

  // stage 2: addresses
  logic [FrameAw-1:0] aa_r, ab_r, ac_r, ad_r;
  logic [3:0] fx2_r, fy2_r;
  logic [FrameAw-1:0] base_a;
  assign base_a = FrameAw'(cfg_r.base_offset) + FrameAw'(py_r[33:16] * cfg_r.row_stride)
                + FrameAw'(px_r[33:16]);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r  <= 1'b0;
      wf2_r <= 1'b0;
      wp2_r <= 1'b0;
    end else if (adv) begin
      v2_r  <= v1_r;
      wf2_r <= wf1_r;
      wp2_r <= wp1_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      aa_r  <= base_a;
      ab_r  <= base_a + FrameAw'(1);
      ac_r  <= base_a + FrameAw'(cfg_r.row_stride);
      ad_r  <= base_a + FrameAw'(cfg_r.row_stride) + FrameAw'(1);
      fx2_r <= px_r[15:12];
      fy2_r <= py_r[15:12];
      wa2_r <= wa1_r;
      wd2_r <= wd1_r;
    end
  end

  // stage 3: frame reads
  logic [4:0] ia_r, ib_r, ic_r, id_r;
  logic [3:0] fx3_r, fy3_r;
  always_ff @(posedge clk) begin
    if (adv && wf2_r) begin
      fb0[wa2_r[FrameAw-1:0]] <= wd2_r[4:0];
      fb1[wa2_r[FrameAw-1:0]] <= wd2_r[4:0];
      fb2[wa2_r[FrameAw-1:0]] <= wd2_r[4:0];
      fb3[wa2_r[FrameAw-1:0]] <= wd2_r[4:0];
    end
    if (adv) begin
      ia_r <= fb0[aa_r];
      ib_r <= fb1[ab_r];
      ic_r <= fb2[ac_r];
      id_r <= fb3[ad_r];
      fx3_r <= fx2_r;
      fy3_r <= fy2_r;
      wa3_r <= wa2_r[PalAw-1:0];
      wd3_r <= wd2_r;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r  <= 1'b0;
      wp3_r <= 1'b0;
    end else if (adv) begin
      v3_r  <= v2_r;
      wp3_r <= wp2_r;
    end
  end

  // stage 4: palette reads
  logic [15:0] ca_r, cb_r, cc_r, cd_r;
  logic [3:0] fx4_r, fy4_r;
  always_ff @(posedge clk) begin
    if (adv && wp3_r)
      pal[wa3_r] <= wd3_r;
    if (adv) begin
      ca_r <= pal[ia_r]; cb_r <= pal[ib_r];
      cc_r <= pal[ic_r]; cd_r <= pal[id_r];
      fx4_r <= fx3_r; fy4_r <= fy3_r;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= v3_r;
  end

  // stage 5: blend (mid register inside blend units)
  logic [15:0] near5_r;
  logic [5:0]  r_o, g_o, b_o;
  logic        mode5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (adv) v5_r <= v4_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      near5_r <= ca_r;
      mode5_r <= cfg_r.scale_mode;
    end
  end

  pis_blend u_r (.clk, .en(adv), .a({1'b0, ca_r[15:11]}), .b({1'b0, cb_r[15:11]}),
    .c({1'b0, cc_r[15:11]}), .d({1'b0, cd_r[15:11]}), .fx(fx4_r), .fy(fy4_r), .res(r_o));
  pis_blend u_g (.clk, .en(adv), .a(ca_r[10:5]), .b(cb_r[10:5]),
    .c(cc_r[10:5]), .d(cd_r[10:5]), .fx(fx4_r), .fy(fy4_r), .res(g_o));
  pis_blend u_b (.clk, .en(adv), .a({1'b0, ca_r[4:0]}), .b({1'b0, cb_r[4:0]}),
    .c({1'b0, cc_r[4:0]}), .d({1'b0, cd_r[4:0]}), .fx(fx4_r), .fy(fy4_r), .res(b_o));

  // stage 6: output register, byte-swapped
  logic [15:0] col;
  logic [15:0] pix_r;
  assign col = mode5_r ? {r_o[4:0], g_o, b_o[4:0]} : near5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (adv) v6_r <= v5_r;
  end
  always_ff @(posedge clk) begin
    if (adv) pix_r <= {col[7:0], col[15:8]};
  end

  assign out_ch.valid = v6_r;
  assign out_ch.pixel = pix_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.pixel))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input blocked with empty output");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    adv && v5_r |=> v6_r)
    else $error("item lost in final stage");

endmodule

FILE: rtl/pis_blend.sv
// ----------------------------------------------------------------------------
// Palette image scaler channel blend
// Two-stage weighted sum of four channel samples with 4-bit fractions.
// ----------------------------------------------------------------------------
module pis_blend
  import pis_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  logic [5:0] a,
  input  logic [5:0] b,
  input  logic [5:0] c,
  input  logic [5:0] d,
  input  logic [3:0] fx,
  input  logic [3:0] fy,
  output logic [5:0] res
);

  logic [4:0]  wx0, wy0;
  logic [10:0] row0_nxt, row1_nxt;
  logic [10:0] row0_r, row1_r;
  logic [4:0]  wy0_r;
  logic [3:0]  fy_r;
  logic [19:0] sum;

  // first stage blends horizontally, second vertically
  assign wx0 = 5'd16 - {1'b0, fx};
  assign wy0 = 5'd16 - {1'b0, fy};
  assign row0_nxt = {5'd0, a} * {6'd0, wx0} + {5'd0, b} * {7'd0, fx};
  assign row1_nxt = {5'd0, c} * {6'd0, wx0} + {5'd0, d} * {7'd0, fx};

  always_ff @(posedge clk) begin
    if (en) begin
      row0_r <= row0_nxt;
      row1_r <= row1_nxt;
      wy0_r  <= wy0;
      fy_r   <= fy;
    end
  end

  assign sum = {9'd0, row0_r} * {15'd0, wy0_r} + {9'd0, row1_r} * {16'd0, fy_r};
  assign res = sum[13:8];

endmodule
